// ===== src/gbns_pkg.sv =====
// Package for the go-back-N sender: field widths, opcodes, result kinds,
// register indexes and the command/status structs between controller and datapath.
// Used by every module of the block; depends on nothing.
package gbns_pkg;

   localparam int SEQ_W             = 16;
   localparam int OPCODE_W          = 2;
   localparam int KIND_W            = 2;
   localparam int CFG_WIN_W         = 6;
   localparam int TIMEOUT_W         = 16;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 16;
   localparam int MAX_WINDOW_DEF    = 32;
   localparam int MAX_RESULTS       = 32;
   localparam int RUN_W             = $clog2(MAX_RESULTS + 1);
   localparam int INIT_WINDOW_RESET = 32;
   localparam int TIMEOUT_RESET     = 200;

   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_WINDOW = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS  = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_START = 2'd0,
      OP_ACK   = 2'd1,
      OP_TICK  = 2'd2
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NEW  = 2'd0,
      KIND_RETX = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef struct packed {
      logic     start;
      logic     ack;
      logic     send;
      logic     wait_tick;
      logic     retx_start;
      logic     retx_step;
      logic     out_load;
      kind_type out_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic active;
      logic count_zero;
      logic ack_ok;
      logic ack_done;
      logic can_send;
      logic timeout;
      logic run_zero;
      logic retx_last;
   } dp_status_type;

endpackage

// ===== src/gbns_ctrl.sv =====
// Controller of the go-back-N sender: decodes accepted beats, steps the
// retransmission run and owns the result valid flag. Depends on gbns_pkg.
module gbns_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [gbns_pkg::OPCODE_W-1:0] req_opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  gbns_pkg::dp_status_type status,
   output gbns_pkg::dp_cmd_type  cmd
);
   import gbns_pkg::*;

   typedef enum logic {
      ST_READY,
      ST_RETX
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_free     = !rsp_valid_ff || !rsp_stall;
      req_stall    = (state_ff == ST_RETX) || !out_free;
      accept       = req_valid && !req_stall;
      unique case (state_ff)
         ST_READY: begin
            if (accept) begin
               unique case (opcode_type'(req_opcode))
                  OP_START: begin
                     cmd.start = 1'b1;
                     if (status.count_zero) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_DONE;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_ACK: begin
                     if (status.active && status.ack_ok) begin
                        cmd.ack = 1'b1;
                        if (status.ack_done) begin
                           cmd.out_load = 1'b1;
                           cmd.out_kind = KIND_DONE;
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end
                  OP_TICK: begin
                     if (status.active) begin
                        if (status.can_send) begin
                           cmd.send     = 1'b1;
                           cmd.out_load = 1'b1;
                           cmd.out_kind = KIND_NEW;
                           rsp_valid_in = 1'b1;
                        end else begin
                           cmd.wait_tick = 1'b1;
                           if (status.timeout) begin
                              cmd.retx_start = 1'b1;
                              if (!status.run_zero) begin
                                 state_in = ST_RETX;
                              end
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RETX: begin
            if (out_free) begin
               cmd.retx_step = 1'b1;
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_RETX;
               rsp_valid_in  = 1'b1;
               if (status.retx_last) begin
                  state_in = ST_READY;
               end
            end
         end
         default: state_in = ST_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/gbns_datapath.sv =====
// Datapath of the go-back-N sender: window and timer state, configuration
// registers, retransmission pointer and the result register. Depends on gbns_pkg.
module gbns_datapath #(
   parameter int MAX_WINDOW = gbns_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [gbns_pkg::SEQ_W-1:0]       req_packet_count,
   input  logic [gbns_pkg::SEQ_W-1:0]       req_ack_number,
   input  logic                             req_ack_corrupt,
   input  logic                             req_ack_type_ok,
   input  logic [gbns_pkg::SEQ_W-1:0]       req_ack_window,
   input  logic                             csr_write,
   input  logic [gbns_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gbns_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  gbns_pkg::dp_cmd_type             cmd,
   output gbns_pkg::dp_status_type          status,
   output logic [gbns_pkg::KIND_W-1:0]      rsp_kind,
   output logic [gbns_pkg::SEQ_W-1:0]       rsp_seq_number,
   output logic [gbns_pkg::SEQ_W-1:0]       rsp_remaining,
   output logic                             rsp_last
);
   import gbns_pkg::*;

   localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
   localparam int WinReset = (INIT_WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : INIT_WINDOW_RESET;

   logic [SEQ_W-1:0]     base_ff, base_in;
   logic [SEQ_W-1:0]     next_ff, next_in;
   logic [SEQ_W-1:0]     total_ff, total_in;
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;
   logic                 active_ff, active_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [SEQ_W-1:0]     retx_seq_ff, retx_seq_in;
   logic [RUN_W-1:0]     retx_left_ff, retx_left_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [SEQ_W-1:0]     seq_ff, seq_in;
   logic [SEQ_W-1:0]     rem_ff, rem_in;
   logic                 last_ff, last_in;

   logic [SEQ_W:0]       ack_plus;
   logic [SEQ_W-1:0]     ack_clamp;
   logic [SEQ_W-1:0]     ack_base;
   logic [SEQ_W:0]       win_limit;
   logic [TIMEOUT_W-1:0] elapsed_inc;
   logic [SEQ_W-1:0]     run;
   logic [RUN_W-1:0]     run_cap;
   logic [WIN_W-1:0]     ack_win_sat;
   logic [WIN_W-1:0]     cfg_win_sat;
   logic [CFG_WIN_W-1:0] cfg_win;

   always_comb begin
      ack_plus  = {1'b0, req_ack_number} + (SEQ_W+1)'(1);
      ack_clamp = (ack_plus > {1'b0, next_ff}) ? next_ff : ack_plus[SEQ_W-1:0];
      ack_base  = (ack_clamp > base_ff) ? ack_clamp : base_ff;
      win_limit = {1'b0, base_ff} + (SEQ_W+1)'(window_ff);
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TIMEOUT_W'(1);
      run       = next_ff - base_ff;
      run_cap   = (run > SEQ_W'(MAX_RESULTS)) ? RUN_W'(MAX_RESULTS) : run[RUN_W-1:0];
      ack_win_sat = (req_ack_window > SEQ_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                          : req_ack_window[WIN_W-1:0];
      cfg_win   = csr_wdata[CFG_WIN_W-1:0];
      cfg_win_sat = (SEQ_W'(cfg_win) > SEQ_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW)
                                                          : WIN_W'(cfg_win);

      status.active     = active_ff;
      status.count_zero = (req_packet_count == '0);
      status.ack_ok     = !req_ack_corrupt && req_ack_type_ok;
      status.ack_done   = (ack_base >= total_ff);
      status.can_send   = (next_ff < total_ff) && ({1'b0, next_ff} < win_limit);
      status.timeout    = (elapsed_inc >= timeout_ff);
      status.run_zero   = (run == '0);
      status.retx_last  = (retx_left_ff == RUN_W'(1));
   end

   always_comb begin
      base_in      = base_ff;
      next_in      = next_ff;
      total_in     = total_ff;
      window_in    = window_ff;
      elapsed_in   = elapsed_ff;
      active_in    = active_ff;
      timeout_in   = timeout_ff;
      retx_seq_in  = retx_seq_ff;
      retx_left_in = retx_left_ff;
      kind_in      = kind_ff;
      seq_in       = seq_ff;
      rem_in       = rem_ff;
      last_in      = last_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_INITIAL_WINDOW: window_in  = cfg_win_sat;
            CSR_TIMEOUT_TICKS:  timeout_in = csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end

      if (cmd.start) begin
         total_in   = req_packet_count;
         base_in    = '0;
         next_in    = '0;
         elapsed_in = '0;
         active_in  = !status.count_zero;
      end
      if (cmd.ack) begin
         base_in   = ack_base;
         window_in = ack_win_sat;
         active_in = !status.ack_done;
      end
      if (cmd.send) begin
         next_in = next_ff + SEQ_W'(1);
         if (next_ff == base_ff) begin
            elapsed_in = '0;
         end
      end
      if (cmd.wait_tick) begin
         elapsed_in = status.timeout ? '0 : elapsed_inc;
      end
      if (cmd.retx_start) begin
         retx_seq_in  = base_ff;
         retx_left_in = run_cap;
      end
      if (cmd.retx_step) begin
         retx_seq_in  = retx_seq_ff + SEQ_W'(1);
         retx_left_in = retx_left_ff - RUN_W'(1);
      end

      if (cmd.out_load) begin
         kind_in = cmd.out_kind;
         case (cmd.out_kind)
            KIND_NEW: begin
               seq_in  = next_ff;
               rem_in  = total_ff - next_ff - SEQ_W'(1);
               last_in = 1'b1;
            end
            KIND_RETX: begin
               seq_in  = retx_seq_ff;
               rem_in  = total_ff - retx_seq_ff - SEQ_W'(1);
               last_in = status.retx_last;
            end
            default: begin
               seq_in  = '0;
               rem_in  = '0;
               last_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         total_ff     <= '0;
         window_ff    <= WIN_W'(WinReset);
         elapsed_ff   <= '0;
         active_ff    <= 1'b0;
         timeout_ff   <= TIMEOUT_W'(TIMEOUT_RESET);
         retx_left_ff <= '0;
      end else begin
         base_ff      <= base_in;
         next_ff      <= next_in;
         total_ff     <= total_in;
         window_ff    <= window_in;
         elapsed_ff   <= elapsed_in;
         active_ff    <= active_in;
         timeout_ff   <= timeout_in;
         retx_left_ff <= retx_left_in;
      end
   end

   always_ff @(posedge clock) begin
      retx_seq_ff <= retx_seq_in;
      kind_ff     <= kind_in;
      seq_ff      <= seq_in;
      rem_ff      <= rem_in;
      last_ff     <= last_in;
   end

   assign rsp_kind       = kind_ff;
   assign rsp_seq_number = seq_ff;
   assign rsp_remaining  = rem_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== src/go_back_n_sender.sv =====
// Go-back-N sender: a sending tick, the start of an empty message or an ack ending the message
// gives its result in the cycle after acceptance; a waiting tick gives none. Request beats are
// taken one per cycle while the result slot is free. A timeout tick with N packets outstanding
// emits min(N, 32) beats from the retransmission state, one per cycle unless rsp_stall holds it;
// input waits meanwhile. Synchronous active-high reset clears the window state, sets window 32
// and timeout 200. Instantiates gbns_ctrl and gbns_datapath; depends on gbns_pkg.
module go_back_n_sender #(
   parameter int MAX_WINDOW = gbns_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [gbns_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [gbns_pkg::SEQ_W-1:0]       req_packet_count,
   input  logic [gbns_pkg::SEQ_W-1:0]       req_ack_number,
   input  logic                             req_ack_corrupt,
   input  logic                             req_ack_type_ok,
   input  logic [gbns_pkg::SEQ_W-1:0]       req_ack_window,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [gbns_pkg::KIND_W-1:0]      rsp_kind,
   output logic [gbns_pkg::SEQ_W-1:0]       rsp_seq_number,
   output logic [gbns_pkg::SEQ_W-1:0]       rsp_remaining,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gbns_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gbns_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gbns_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   gbns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   gbns_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_packet_count (req_packet_count),
      .req_ack_number   (req_ack_number),
      .req_ack_corrupt  (req_ack_corrupt),
      .req_ack_type_ok  (req_ack_type_ok),
      .req_ack_window   (req_ack_window),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_kind         (rsp_kind),
      .rsp_seq_number   (rsp_seq_number),
      .rsp_remaining    (rsp_remaining),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== src/gbns_checker.sv =====
// Port-level checks for the go-back-N sender, attached to the top level by bind.
// Depends on gbns_pkg and go_back_n_sender.
module gbns_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [gbns_pkg::OPCODE_W-1:0]    req_opcode,
   input logic [gbns_pkg::SEQ_W-1:0]       req_packet_count,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [gbns_pkg::KIND_W-1:0]      rsp_kind,
   input logic [gbns_pkg::SEQ_W-1:0]       rsp_seq_number,
   input logic [gbns_pkg::SEQ_W-1:0]       rsp_remaining,
   input logic                             rsp_last
);
   import gbns_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seq_number) && $stable(rsp_kind))
      else $error("result beat changed while stalled");

   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |->
         rsp_seq_number == '0 && rsp_remaining == '0 && rsp_last)
      else $error("done beat carries sequence data");

   a_new_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_NEW |-> rsp_last)
      else $error("new packet beat is not marked last");

   a_empty_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_START && req_packet_count == '0 |=>
         rsp_valid && rsp_kind == KIND_DONE)
      else $error("empty message did not report done");

   a_run_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && rsp_kind == KIND_RETX &&
         rsp_seq_number == $past(rsp_seq_number) + 16'd1)
      else $error("retransmission run broken");

endmodule

bind go_back_n_sender gbns_checker u_gbns_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_opcode       (req_opcode),
   .req_packet_count (req_packet_count),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_seq_number   (rsp_seq_number),
   .rsp_remaining    (rsp_remaining),
   .rsp_last         (rsp_last)
);

// ===== tb/go_back_n_sender_tb.sv =====
// Self-checking testbench for the go-back-N sender: a directed table, then random messages.
// Expected beats come from an in-bench window predictor and are checked in order.
// Depends on gbns_pkg and go_back_n_sender.
`timescale 1ns / 1ps

module go_back_n_sender_tb;
   import gbns_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int PLAN_LEN     = 32;
   localparam int RANDOM_ITEMS = 300;
   localparam int QUIET_AFTER  = 260;
   localparam int HOLD_AT      = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 8;
   localparam int DRAIN        = 20;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SEQ_W-1:0]    count;
      logic [SEQ_W-1:0]    ack_num;
      logic                corrupt;
      logic                type_ok;
      logic [SEQ_W-1:0]    win;
   } req_type;

   typedef struct packed {
      kind_type         kind;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] remaining;
      logic             last;
   } beat_type;

   typedef struct packed {
      logic                   is_reg;
      logic [CSR_INDEX_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0]  reg_data;
      req_type                req;
      logic                   typed;
      beat_type               want;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [SEQ_W-1:0]       req_packet_count;
   logic [SEQ_W-1:0]       req_ack_number;
   logic                   req_ack_corrupt;
   logic                   req_ack_type_ok;
   logic [SEQ_W-1:0]       req_ack_window;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [KIND_W-1:0]      rsp_kind;
   logic [SEQ_W-1:0]       rsp_seq_number;
   logic [SEQ_W-1:0]       rsp_remaining;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   beat_type     packets_due[$];
   plan_row_type plan [PLAN_LEN];

   logic [SEQ_W-1:0]     win_base    = '0;
   logic [SEQ_W-1:0]     seq_next    = '0;
   logic [SEQ_W-1:0]     msg_packets = '0;
   logic [CFG_WIN_W-1:0] win_size    = CFG_WIN_W'(INIT_WINDOW_RESET);
   logic [TIMEOUT_W-1:0] wait_ticks  = '0;
   logic                 msg_open    = 1'b0;
   logic [TIMEOUT_W-1:0] cfg_timeout = TIMEOUT_W'(TIMEOUT_RESET);

   int mismatches   = 0;
   int cycle_count  = 0;
   int random_items = 0;
   int gap_pct      = 25;
   bit quiet        = 1'b0;
   bit hold_rsp     = 1'b0;
   bit held         = 1'b0;

   go_back_n_sender dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_packet_count (req_packet_count),
      .req_ack_number   (req_ack_number),
      .req_ack_corrupt  (req_ack_corrupt),
      .req_ack_type_ok  (req_ack_type_ok),
      .req_ack_window   (req_ack_window),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_seq_number   (rsp_seq_number),
      .rsp_remaining    (rsp_remaining),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [CFG_WIN_W-1:0] clip_window(input logic [SEQ_W-1:0] w);
      return (w > SEQ_W'(MAX_WINDOW_DEF)) ? CFG_WIN_W'(MAX_WINDOW_DEF) : w[CFG_WIN_W-1:0];
   endfunction

   function automatic plan_row_type item_row(input logic [OPCODE_W-1:0] op,
                                             input logic [SEQ_W-1:0] count,
                                             input logic [SEQ_W-1:0] ack_num,
                                             input logic corrupt, input logic type_ok,
                                             input logic [SEQ_W-1:0] win);
      plan_row_type r;
      r = '0;
      r.req = '{op, count, ack_num, corrupt, type_ok, win};
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.is_reg   = 1'b1;
      r.reg_idx  = idx;
      r.reg_data = data;
      return r;
   endfunction

   function automatic plan_row_type known(input plan_row_type r, input kind_type k,
                                          input logic [SEQ_W-1:0] s,
                                          input logic [SEQ_W-1:0] rem);
      r.typed = 1'b1;
      r.want  = '{k, s, rem, 1'b1};
      return r;
   endfunction

   task automatic queue_beat(input beat_type b);
      packets_due.insert(packets_due.size(), b);
   endtask

   task automatic advance_window(input req_type r);
      logic [SEQ_W:0]   nb;
      logic [SEQ_W-1:0] run;
      if (r.opcode == OP_START) begin
         msg_packets = r.count;
         win_base    = '0;
         seq_next    = '0;
         wait_ticks  = '0;
         msg_open    = (r.count != '0);
         if (r.count == '0) queue_beat(beat_type'{KIND_DONE, '0, '0, 1'b1});
      end else if (msg_open && r.opcode == OP_ACK) begin
         if (!r.corrupt && r.type_ok) begin
            nb = {1'b0, r.ack_num} + 1'b1;
            if (nb > {1'b0, seq_next}) nb = {1'b0, seq_next};
            if (nb > {1'b0, win_base}) win_base = nb[SEQ_W-1:0];
            win_size = clip_window(r.win);
            if (win_base >= msg_packets) begin
               msg_open = 1'b0;
               queue_beat(beat_type'{KIND_DONE, '0, '0, 1'b1});
            end
         end
      end else if (msg_open && r.opcode == OP_TICK) begin
         if (seq_next < msg_packets && {1'b0, seq_next} < {1'b0, win_base} + win_size) begin
            queue_beat(beat_type'{KIND_NEW, seq_next, msg_packets - seq_next - 1'b1, 1'b1});
            if (seq_next == win_base) wait_ticks = '0;
            seq_next = seq_next + 1'b1;
         end else begin
            if (wait_ticks != '1) wait_ticks = wait_ticks + 1'b1;
            if (wait_ticks >= cfg_timeout) begin
               run = seq_next - win_base;
               if (run > SEQ_W'(MAX_RESULTS)) run = SEQ_W'(MAX_RESULTS);
               for (int i = 0; i < int'(run); i++) begin
                  queue_beat(beat_type'{KIND_RETX, win_base + SEQ_W'(i),
                                        msg_packets - win_base - SEQ_W'(i) - 1'b1,
                                        (i + 1 == int'(run))});
               end
               wait_ticks = '0;
            end
         end
      end
   endtask

   task automatic offer(input req_type r);
      if (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= r.opcode;
      req_packet_count <= r.count;
      req_ack_number   <= r.ack_num;
      req_ack_corrupt  <= r.corrupt;
      req_ack_type_ok  <= r.type_ok;
      req_ack_window   <= r.win;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (packets_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_INITIAL_WINDOW) win_size = clip_window({10'd0, data[CFG_WIN_W-1:0]});
      else cfg_timeout = data;
   endtask

   task automatic issue(input req_type r);
      advance_window(r);
      offer(r);
      if (r.opcode != OP_UNUSED) random_items++;
      if (!held && random_items == HOLD_AT) begin
         hold_rsp = 1'b1;
         held     = 1'b1;
      end
      quiet = (random_items >= QUIET_AFTER);
   endtask

   function automatic req_type next_request();
      req_type     r;
      int unsigned dice;
      int unsigned k;
      r.opcode  = OP_TICK;
      r.count   = SEQ_W'($urandom);
      r.ack_num = SEQ_W'($urandom);
      r.corrupt = 1'($urandom_range(1));
      r.type_ok = 1'($urandom_range(1));
      r.win     = SEQ_W'($urandom);
      dice = $urandom_range(99);
      if (dice < 4) begin
         r.opcode = OP_UNUSED;
      end else if (dice < 6) begin
         r.opcode = OP_START;
         r.count  = SEQ_W'($urandom_range(1, 40));
      end else if (dice >= 66) begin
         r.opcode  = OP_ACK;
         r.corrupt = ($urandom_range(99) < 6);
         r.type_ok = ($urandom_range(99) >= 6);
         if ($urandom_range(99) < 85) begin
            k = $urandom_range(int'(seq_next - win_base));
            r.ack_num = (win_base == '0 && k == 0) ? '0 : SEQ_W'(win_base + k - 1);
         end
         if ($urandom_range(99) < 80) r.win = SEQ_W'($urandom_range(0, 40));
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin : check_beat
      beat_type got;
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{kind_type'(rsp_kind), rsp_seq_number, rsp_remaining, rsp_last};
         if (packets_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: kind=%0d seq=%0d remaining=%0d last=%0d",
                        got.kind, got.seq, got.remaining, got.last);
         end else begin
            want = packets_due.pop_front();
            if (got.kind !== want.kind || got.seq !== want.seq ||
                got.remaining !== want.remaining || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat mismatch: expected kind=%0d seq=%0d remaining=%0d last=%0d, %s",
                           want.kind, want.seq, want.remaining, want.last,
                           $sformatf("actual kind=%0d seq=%0d remaining=%0d last=%0d",
                                     got.kind, got.seq, got.remaining, got.last));
            end
         end
      end
   end

   initial begin : rsp_pacing
      bit stall_now;
      int span;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            stall_now = 1'b1;
            span      = HOLD_CYCLES;
            hold_rsp  = 1'b0;
         end else if (quiet) begin
            stall_now = 1'b0;
            span      = 1;
         end else if ($urandom_range(3) == 0) begin
            stall_now = 1'b1;
            span      = $urandom_range(1, 10);
         end else begin
            stall_now = 1'b0;
            span      = $urandom_range(1, 30);
         end
         rsp_stall <= stall_now;
         repeat (span) @(posedge clock);
      end
   end

   initial begin : stimulus
      req_type          r;
      int               depth;
      int               budget;
      logic [SEQ_W-1:0] data;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= OP_TICK;
      req_packet_count <= '0;
      req_ack_number   <= '0;
      req_ack_corrupt  <= 1'b0;
      req_ack_type_ok  <= 1'b0;
      req_ack_window   <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= CSR_INITIAL_WINDOW;
      csr_wdata        <= '0;
      plan = '{
         item_row(OP_TICK, 16'd7, 16'd0, 1'b0, 1'b1, 16'd0),
         item_row(OP_ACK, 16'd0, 16'd0, 1'b0, 1'b1, 16'd5),
         item_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF),
         known(item_row(OP_START, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0), KIND_DONE, 16'd0, 16'd0),
         csr_row(CSR_TIMEOUT_TICKS, 16'd0),
         csr_row(CSR_INITIAL_WINDOW, 16'd2),
         item_row(OP_START, 16'hFFFF, 16'd0, 1'b0, 1'b0, 16'd0),
         known(item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0), KIND_NEW, 16'd0, 16'd65534),
         known(item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0), KIND_NEW, 16'd1, 16'd65533),
         item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0),
         item_row(OP_ACK, 16'd0, 16'd1, 1'b1, 1'b1, 16'd4),
         item_row(OP_ACK, 16'd0, 16'd1, 1'b0, 1'b0, 16'd4),
         item_row(OP_ACK, 16'd0, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF),
         item_row(OP_ACK, 16'd0, 16'd0, 1'b0, 1'b1, 16'd0),
         item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0),
         item_row(OP_ACK, 16'd0, 16'd1, 1'b0, 1'b1, 16'd3),
         item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0),
         csr_row(CSR_INITIAL_WINDOW, 16'd63),
         csr_row(CSR_TIMEOUT_TICKS, 16'hFFFF),
         item_row(OP_START, 16'd3, 16'd0, 1'b0, 1'b0, 16'd0),
         known(item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0), KIND_NEW, 16'd0, 16'd2),
         item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0),
         item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0),
         item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0),
         known(item_row(OP_ACK, 16'd0, 16'd2, 1'b0, 1'b1, 16'd1), KIND_DONE, 16'd0, 16'd0),
         item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0),
         csr_row(CSR_INITIAL_WINDOW, 16'd0),
         item_row(OP_START, 16'd1, 16'd0, 1'b0, 1'b0, 16'd0),
         item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0),
         item_row(OP_ACK, 16'd0, 16'hFFFF, 1'b0, 1'b1, 16'd1),
         known(item_row(OP_TICK, 16'd0, 16'd0, 1'b0, 1'b0, 16'd0), KIND_NEW, 16'd0, 16'd0),
         known(item_row(OP_ACK, 16'd0, 16'd0, 1'b0, 1'b1, 16'd32), KIND_DONE, 16'd0, 16'd0)
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            write_reg(plan[i].reg_idx, plan[i].reg_data);
         end else begin
            depth = packets_due.size();
            advance_window(plan[i].req);
            if (plan[i].typed) begin
               while (packets_due.size() > depth) packets_due.delete(packets_due.size() - 1);
               queue_beat(plan[i].want);
            end
            offer(plan[i].req);
         end
      end

      // Each pass configures the window and timer, then runs one message.
      while (random_items < RANDOM_ITEMS) begin
         gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 40);
         case ($urandom_range(4))
            0: data = 16'd0;
            1: data = SEQ_W'($urandom_range(32, 63));
            default: data = SEQ_W'($urandom_range(1, 31));
         endcase
         data[15:6] = 10'($urandom);
         write_reg(CSR_INITIAL_WINDOW, data);
         case ($urandom_range(19))
            0, 1: data = 16'd0;
            2: data = SEQ_W'($urandom);
            3, 4, 5, 6: data = SEQ_W'($urandom_range(10, 40));
            default: data = SEQ_W'($urandom_range(1, 6));
         endcase
         write_reg(CSR_TIMEOUT_TICKS, data);
         r = next_request();
         r.opcode = OP_START;
         case ($urandom_range(15))
            0: r.count = '0;
            1: r.count = SEQ_W'($urandom);
            default: r.count = SEQ_W'($urandom_range(1, 40));
         endcase
         issue(r);
         budget = $urandom_range(20, 70);
         while (budget > 0 && msg_open && random_items < RANDOM_ITEMS) begin
            issue(next_request());
            budget--;
         end
      end

      req_valid <= 1'b0;
      while (packets_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
